// ----- src/pkvs_pkg.sv -----
// shared constants, opcodes and helpers for the permutation keyed value store
`timescale 1ns / 1ps

package pkvs_pkg;

    // largest supported permutation length and element width
    localparam int MAX_PERM  = 8;
    localparam int KEY_W     = 3;
    localparam int OP_W      = 2;
    localparam int VAL_W     = 64;

    // stream word layout, lowest field first
    localparam int IN_KEY_LSB  = OP_W;
    localparam int IN_RE_LSB   = IN_KEY_LSB + MAX_PERM * KEY_W;
    localparam int IN_IM_LSB   = IN_RE_LSB + VAL_W;
    localparam int IN_BITS     = IN_IM_LSB + VAL_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_IM_LSB  = VAL_W;
    localparam int OUT_ST_BIT  = 2 * VAL_W;
    localparam int OUT_BITS    = 2 * VAL_W + 1;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // opcodes
    localparam logic [OP_W-1:0] OP_PUT_AMP = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT_COL = 2'd1;
    localparam logic [OP_W-1:0] OP_GET_AMP = 2'd2;
    localparam logic [OP_W-1:0] OP_GET_COL = 2'd3;

    // status codes
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_BAD_KEY = 1'b1;

    // factorial weights of the mixed-radix index
    typedef logic [15:0] t_fact_arr [0:MAX_PERM];
    localparam t_fact_arr FACT = '{16'd1, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120,
                                   16'd720, 16'd5040, 16'd40320};

    // entry count for a given permutation length
    function automatic int perm_entries(input int len);
        int acc;
        acc = 1;
        for (int n = 2; n <= len; n++) begin
            acc = acc * n;
        end
        return acc;
    endfunction

endpackage

// ----- src/permutation_keyed_value_store_unit.sv -----
// top level: permutation ranking, amplitude and colour stores, result register
`timescale 1ns / 1ps
// result: registered; a word accepted at a clock edge shows its result at the output in the next cycle
// throughput: one word per cycle while the output is taken; set by the single store port
// an unread result blocks input until it is taken
// reset: synchronous, active low; afterwards both stores are swept to zero over all
// PERM_LEN! entries (720 at the default length), and no word is accepted meanwhile

module permutation_keyed_value_store_unit #(
    parameter int PERM_LEN = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // opcode, key_0 .. key_7, value_re, value_im, zero pad
    input  logic [pkvs_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // read_re, read_im, status, zero pad
    output logic [pkvs_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import pkvs_pkg::*;

    localparam int DEPTH  = perm_entries(PERM_LEN);
    localparam int ADDR_W = $clog2(DEPTH);

    // input fields
    logic [OP_W-1:0]  w_op;
    logic [KEY_W-1:0] w_key [0:MAX_PERM-1];
    logic [VAL_W-1:0] w_val_re;
    logic [VAL_W-1:0] w_val_im;

    assign w_op     = i_s_tdata[OP_W-1:0];
    assign w_val_re = i_s_tdata[IN_RE_LSB +: VAL_W];
    assign w_val_im = i_s_tdata[IN_IM_LSB +: VAL_W];

    genvar g;
    generate
        for (g = 0; g < MAX_PERM; g++) begin : g_key
            assign w_key[g] = i_s_tdata[IN_KEY_LSB + g*KEY_W +: KEY_W];
        end
    endgenerate

    // ranking: per level, count the still present elements ahead of value s-1
    logic                 w_first [0:MAX_PERM-1];
    logic                 w_valid;
    logic [15:0]          w_rank;
    logic [ADDR_W-1:0]    w_idx;

    always_comb begin
        logic       seen;
        logic [2:0] cnt;
        // first occurrence marks, removal only takes the first copy of a value
        for (int i = 0; i < MAX_PERM; i++) begin
            w_first[i] = 1'b1;
            for (int k = 0; k < i; k++) begin
                if (w_key[k] == w_key[i]) begin
                    w_first[i] = 1'b0;
                end
            end
        end
        w_valid = 1'b1;
        w_rank  = 16'd0;
        for (int s = 2; s <= PERM_LEN; s++) begin
            seen = 1'b0;
            cnt  = 3'd0;
            for (int i = 0; i < PERM_LEN; i++) begin
                if (w_key[i] == KEY_W'(s - 1)) begin
                    seen = 1'b1;
                end else if (!seen && !(w_first[i] && ({1'b0, w_key[i]} >= 4'(s))
                             && ({1'b0, w_key[i]} < 4'(PERM_LEN)))) begin
                    cnt = cnt + 3'd1;
                end
            end
            if (!seen) begin
                w_valid = 1'b0;
            end
            w_rank = w_rank + 16'(16'(cnt) * FACT[s-1]);
        end
    end

    assign w_idx = w_rank[ADDR_W-1:0];

    // clearing sweep after reset
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // handshake
    logic r_out_valid;
    logic w_accept;
    logic w_is_get;
    logic w_sel_col;

    assign o_s_tready = !r_clearing && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_is_get   = (w_op == OP_GET_AMP) || (w_op == OP_GET_COL);
    assign w_sel_col  = (w_op == OP_PUT_COL) || (w_op == OP_GET_COL);

    // store port controls
    logic                 w_amp_we;
    logic                 w_col_we;
    logic                 w_amp_re;
    logic                 w_col_re;
    logic [ADDR_W-1:0]    w_addr;
    logic [2*VAL_W-1:0]   w_wdata;

    assign w_addr   = r_clearing ? r_clr_addr : w_idx;
    assign w_wdata  = r_clearing ? '0 : {w_val_im, w_val_re};
    assign w_amp_we = r_clearing || (w_accept && w_valid && !w_is_get && !w_sel_col);
    assign w_col_we = r_clearing || (w_accept && w_valid && !w_is_get && w_sel_col);
    assign w_amp_re = w_accept && w_valid && w_is_get && !w_sel_col;
    assign w_col_re = w_accept && w_valid && w_is_get && w_sel_col;

    // amplitude store, {im, re} per entry
    logic [2*VAL_W-1:0] r_amp_mem [0:DEPTH-1];
    logic [2*VAL_W-1:0] r_amp_rd;

    always_ff @(posedge i_clk) begin
        if (w_amp_we) begin
            r_amp_mem[w_addr] <= w_wdata;
        end
        if (w_amp_re) begin
            r_amp_rd <= r_amp_mem[w_addr];
        end
    end

    // colour store, {im, re} per entry
    logic [2*VAL_W-1:0] r_col_mem [0:DEPTH-1];
    logic [2*VAL_W-1:0] r_col_rd;

    always_ff @(posedge i_clk) begin
        if (w_col_we) begin
            r_col_mem[w_addr] <= w_wdata;
        end
        if (w_col_re) begin
            r_col_rd <= r_col_mem[w_addr];
        end
    end

    // result register
    logic r_zero;
    logic r_status;
    logic r_sel_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_zero    <= !(w_valid && w_is_get);
            r_status  <= w_valid ? ST_DONE : ST_BAD_KEY;
            r_sel_col <= w_sel_col;
        end
    end

    // output word
    logic [2*VAL_W-1:0] w_rd;

    assign w_rd       = r_zero ? '0 : (r_sel_col ? r_col_rd : r_amp_rd);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, r_status, w_rd};

endmodule

// ----- src/pkvs_checker.sv -----
// port level checks for the permutation keyed value store and their binding
`timescale 1ns / 1ps

module pkvs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [pkvs_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [pkvs_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import pkvs_pkg::*;

    // no result word right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word shown after reset");

    // every accepted word gives a result the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted word without result");

    // input waits while a result is held back
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while result stalled");

    // a bad key returns zero data
    a_bad_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[OUT_ST_BIT] == ST_BAD_KEY))
        |-> (o_m_tdata[2*VAL_W-1:0] == '0))
        else $error("bad key with nonzero data");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind permutation_keyed_value_store_unit pkvs_checker u_pkvs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- verif/permutation_keyed_value_store_unit_tb.sv -----
// testbench for the permutation keyed value store: directed table, random traffic, scoreboard
`timescale 1ns / 1ps

module permutation_keyed_value_store_unit_tb;
    import pkvs_pkg::*;

    localparam int PERM_LEN = 6;
    localparam int ENTRIES  = perm_entries(PERM_LEN);
    localparam int KEY_BITS = MAX_PERM * KEY_W;
    localparam int TAIL_W   = (MAX_PERM - PERM_LEN) * KEY_W;
    localparam int HALF_PER = 6;

    typedef logic [KEY_BITS-1:0] t_key;

    // one result word, unpacked
    typedef struct {
        logic [VAL_W-1:0] re;
        logic [VAL_W-1:0] im;
        logic             st;
    } t_reply;

    // one request word plus an optional hand-typed answer
    typedef struct {
        logic [OP_W-1:0]  op;
        t_key             key;
        logic [VAL_W-1:0] re;
        logic [VAL_W-1:0] im;
        bit               typed;
        t_reply           answer;
    } t_access;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    // shadow copies of both tables
    logic [VAL_W-1:0] amp_re_mem [ENTRIES];
    logic [VAL_W-1:0] amp_im_mem [ENTRIES];
    logic [VAL_W-1:0] col_re_mem [ENTRIES];
    logic [VAL_W-1:0] col_im_mem [ENTRIES];

    t_reply      pending_replies [$];
    t_access     directed_rows [$];
    t_key        key_pool [$];
    bit          no_idle;
    int unsigned mismatches;
    int unsigned words_seen;
    int unsigned n_puts;
    int unsigned n_gets;
    int unsigned n_bad;

    permutation_keyed_value_store_unit #(
        .PERM_LEN(PERM_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #(HALF_PER) i_clk = ~i_clk;

    // run limit
    initial begin
        #5_000_000;
        $display("timeout with %0d words still expected", pending_replies.size());
        $display("FAIL");
        $finish;
    end

    // pack eight key elements, key_0 in the low bits
    function automatic t_key perm_key(input int k0, k1, k2, k3, k4, k5, k6, k7);
        return {k7[2:0], k6[2:0], k5[2:0], k4[2:0], k3[2:0], k2[2:0], k1[2:0], k0[2:0]};
    endfunction

    // level-by-level rank of the key; zero return means not a permutation
    function automatic bit rank_perm_key(input t_key key, output int idx);
        int rest [MAX_PERM];
        int pos;
        idx = 0;
        for (int i = 0; i < PERM_LEN; i++) begin
            rest[i] = int'(key[i*KEY_W +: KEY_W]);
        end
        for (int s = PERM_LEN; s >= 2; s--) begin
            pos = s;
            for (int i = s - 1; i >= 0; i--) begin
                if (rest[i] == s - 1) begin
                    pos = i;
                end
            end
            if (pos == s) begin
                return 1'b0;
            end
            for (int i = pos; i + 1 < s; i++) begin
                rest[i] = rest[i + 1];
            end
            idx = idx * s + pos;
        end
        return idx < ENTRIES;
    endfunction

    // apply one access to the shadow tables and return the answer
    function automatic t_reply store_access(input t_access a);
        t_reply r;
        int     idx;
        r = '{re: '0, im: '0, st: ST_DONE};
        if (!rank_perm_key(a.key, idx)) begin
            r.st = ST_BAD_KEY;
            n_bad++;
            return r;
        end
        case (a.op)
            OP_PUT_AMP: begin
                amp_re_mem[idx] = a.re;
                amp_im_mem[idx] = a.im;
                n_puts++;
            end
            OP_PUT_COL: begin
                col_re_mem[idx] = a.re;
                col_im_mem[idx] = a.im;
                n_puts++;
            end
            OP_GET_AMP: begin
                r.re = amp_re_mem[idx];
                r.im = amp_im_mem[idx];
                n_gets++;
            end
            default: begin
                r.re = col_re_mem[idx];
                r.im = col_im_mem[idx];
                n_gets++;
            end
        endcase
        return r;
    endfunction

    function automatic t_access make_access(input logic [OP_W-1:0] op, input t_key key,
                                            input logic [VAL_W-1:0] re, im);
        t_access a;
        a.op     = op;
        a.key    = key;
        a.re     = re;
        a.im     = im;
        a.typed  = 1'b0;
        a.answer = '{re: '0, im: '0, st: ST_DONE};
        return a;
    endfunction

    // typed rows answer with zero data; only the status varies
    task automatic add_row(input logic [OP_W-1:0] op, input t_key key,
                           input logic [VAL_W-1:0] re, im, input bit typed, input logic st);
        t_access a;
        a = make_access(op, key, re, im);
        a.typed = typed;
        a.answer.st = st;
        directed_rows.insert(directed_rows.size(), a);
    endtask

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got, exp);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, exp);
        mismatches++;
    endtask

    // offer one word after a random gap and wait for the handshake; called at a falling edge
    task automatic send_word(input t_access a);
        int                   gap;
        logic [IN_DATA_W-1:0] w;
        t_reply               r;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        w = '0;
        w[OP_W-1:0]                 = a.op;
        w[IN_KEY_LSB +: KEY_BITS]   = a.key;
        w[IN_RE_LSB +: VAL_W]       = a.re;
        w[IN_IM_LSB +: VAL_W]       = a.im;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        do @(posedge i_clk); while (!o_s_tready);
        r = store_access(a);
        pending_replies.insert(pending_replies.size(), a.typed ? a.answer : r);
        @(negedge i_clk);
    endtask

    // random permutation of the first PERM_LEN elements, random tail
    function automatic t_key random_perm();
        int   p [MAX_PERM];
        int   j;
        int   t;
        t_key k;
        for (int i = 0; i < MAX_PERM; i++) begin
            p[i] = (i < PERM_LEN) ? i : $urandom_range(0, 7);
        end
        for (int i = PERM_LEN - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = p[i];
            p[i] = p[j];
            p[j] = t;
        end
        for (int i = 0; i < MAX_PERM; i++) begin
            k[i*KEY_W +: KEY_W] = p[i][KEY_W-1:0];
        end
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // pick a key: many reused permutations so gets hit written entries, new ones, some noise
    function automatic t_key random_key();
        int   pick;
        t_key k;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            k = KEY_BITS'($urandom);
        end else if (pick < 16) begin
            k = random_perm();
            k[$urandom_range(0, PERM_LEN - 1)*KEY_W +: KEY_W] = KEY_W'($urandom_range(0, 7));
        end else if (pick < 60 && key_pool.size() > 0) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            k[PERM_LEN*KEY_W +: TAIL_W] = TAIL_W'($urandom);
        end else begin
            k = random_perm();
            key_pool.insert(key_pool.size(), k);
            if (key_pool.size() > 24) begin
                void'(key_pool.pop_front());
            end
        end
        return k;
    endfunction

    // result receiver with random stalls and one long hold-off
    initial begin
        int stall;
        int taken;
        taken = 0;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (taken == 400) begin
                stall = 200;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 18);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            taken++;
            @(negedge i_clk);
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_reply e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            words_seen++;
            if (pending_replies.size() == 0) begin
                report_mismatch("word with nothing expected", o_m_tdata[VAL_W-1:0], '0);
            end else begin
                e = pending_replies.pop_front();
                if (o_m_tdata[VAL_W-1:0] !== e.re) begin
                    report_mismatch("read_re", o_m_tdata[VAL_W-1:0], e.re);
                end
                if (o_m_tdata[OUT_IM_LSB +: VAL_W] !== e.im) begin
                    report_mismatch("read_im", o_m_tdata[OUT_IM_LSB +: VAL_W], e.im);
                end
                if (o_m_tdata[OUT_ST_BIT] !== e.st) begin
                    report_mismatch("status", VAL_W'(o_m_tdata[OUT_ST_BIT]), VAL_W'(e.st));
                end
            end
        end
    end

    // main sequence
    initial begin
        t_key ident;
        t_key rev;
        ident = perm_key(0, 1, 2, 3, 4, 5, 0, 0);
        rev   = perm_key(5, 4, 3, 2, 1, 0, 0, 0);
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        no_idle    = 1'b0;
        mismatches = 0;
        words_seen = 0;
        n_puts     = 0;
        n_gets     = 0;
        n_bad      = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            amp_re_mem[i] = '0;
            amp_im_mem[i] = '0;
            col_re_mem[i] = '0;
            col_im_mem[i] = '0;
        end

        // directed rows: empty tables, extremes, bad keys, unused key positions
        add_row(OP_GET_AMP, ident, '1, '1, 1, ST_DONE);
        add_row(OP_GET_COL, rev, '0, '0, 1, ST_DONE);
        add_row(OP_PUT_AMP, ident, '1, '1, 1, ST_DONE);
        add_row(OP_PUT_COL, ident, '0, 64'h8000_0000_0000_0001, 1, ST_DONE);
        add_row(OP_GET_AMP, ident, '0, '0, 0, ST_DONE);
        add_row(OP_GET_COL, ident, '1, '1, 0, ST_DONE);
        add_row(OP_PUT_AMP, perm_key(5, 4, 3, 2, 1, 0, 7, 7), 64'h7ff0_0000_0000_0000, '1,
                1, ST_DONE);
        add_row(OP_GET_AMP, perm_key(5, 4, 3, 2, 1, 0, 0, 5), '0, '0, 0, ST_DONE);
        // the element left after the last level is never looked at, so this key still ranks
        add_row(OP_PUT_COL, perm_key(7, 1, 2, 3, 4, 5, 0, 0), '1, '1, 1, ST_DONE);
        add_row(OP_GET_COL, perm_key(0, 0, 2, 3, 4, 5, 0, 0), '0, '0, 1, ST_BAD_KEY);
        add_row(OP_GET_AMP, perm_key(6, 1, 2, 3, 4, 0, 0, 0), '0, '0, 1, ST_BAD_KEY);
        add_row(OP_PUT_AMP, perm_key(7, 7, 7, 7, 7, 7, 7, 7), '1, '1, 1, ST_BAD_KEY);
        add_row(OP_GET_AMP, ident, '0, '0, 0, ST_DONE);
        add_row(OP_PUT_COL, perm_key(1, 0, 2, 3, 4, 5, 0, 0), {16{4'ha}}, {16{4'h5}},
                1, ST_DONE);
        add_row(OP_GET_COL, perm_key(1, 0, 2, 3, 4, 5, 3, 6), '0, '0, 0, ST_DONE);
        add_row(OP_PUT_AMP, perm_key(0, 1, 2, 3, 5, 4, 0, 0), {16{4'h5}}, {16{4'ha}},
                1, ST_DONE);
        add_row(OP_GET_AMP, perm_key(0, 1, 2, 3, 5, 4, 0, 0), '0, '0, 0, ST_DONE);
        add_row(OP_GET_COL, perm_key(0, 0, 0, 0, 0, 0, 0, 0), '0, '0, 1, ST_BAD_KEY);
        add_row(OP_GET_COL, rev, '0, '0, 0, ST_DONE);
        add_row(OP_GET_AMP, rev, '0, '0, 0, ST_DONE);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i]);
        end

        // drain before random traffic
        i_s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);

        // random traffic with bursts where neither side idles
        for (int n = 0; n < 1150; n++) begin
            no_idle = ((n / 60) % 5) == 4;
            if (n == 700) begin
                i_s_tvalid <= 1'b0;
                while (pending_replies.size() != 0) @(negedge i_clk);
            end
            send_word(make_access(OP_W'($urandom_range(0, 3)), random_key(), random_value(),
                                  random_value()));
        end
        i_s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d puts, %0d gets and %0d bad keys over %0d result words",
                 n_puts, n_gets, n_bad, words_seen);
        $display("%0d mismatches seen", mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
